FILE: src/cpci_pkg.sv
// Package for the circle pair collision impulse block.
// Holds the fixed-point widths, the pipeline word types and the saturation helper.
// Used by every module under src.
package cpci_pkg;

    // fixed-point format: signed Q(31-FRAC_BITS).FRAC_BITS, range 8..24
    localparam int FRAC_BITS = 16;

    localparam int POS_W = 32;
    localparam int VEL_W = 32;
    localparam int RAD_W = 8;

    // centre / velocity difference, exact
    localparam int DIF_W = POS_W + 1;
    // radius sum in fixed point; bounds |dx|, |dy| and the root when collided
    localparam int RQ_W  = RAD_W + 1 + FRAC_BITS;
    localparam int D2_W  = 2 * RQ_W + 1;
    // radicand handed to the square root
    localparam int SQ_W  = 2 * RQ_W;
    localparam int REM_W = RQ_W + 2;
    // dividend width of the three divider lanes
    localparam int NUM_W = RQ_W + FRAC_BITS;
    // signed normal component, |n| <= 1.0
    localparam int N_W   = FRAC_BITS + 2;
    // ratio split for the two partial products
    localparam int RL_W  = NUM_W / 2;
    localparam int RH_W  = NUM_W - RL_W;
    localparam int PP_W  = NUM_W + RQ_W;
    // dot product chain
    localparam int MP_W  = N_W + DIF_W;
    localparam int SUM_W = MP_W + 1;
    localparam int DOT_W = SUM_W - FRAC_BITS;
    localparam int IP_W  = N_W + DOT_W;
    localparam int IS_W  = IP_W - FRAC_BITS - 1;
    // signed push before saturation
    localparam int PX_W  = RQ_W + 1;

    // divider lanes
    localparam int LANES  = 3;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_R = 2;

    // accept edge to the edge that takes the result
    localparam int LATENCY = 9 + RQ_W + NUM_W;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    // one input word
    typedef struct packed {
        logic signed [POS_W-1:0] a_pos_x;
        logic signed [POS_W-1:0] a_pos_y;
        logic        [RAD_W-1:0] a_radius;
        logic signed [VEL_W-1:0] a_vel_x;
        logic signed [VEL_W-1:0] a_vel_y;
        logic signed [POS_W-1:0] b_pos_x;
        logic signed [POS_W-1:0] b_pos_y;
        logic        [RAD_W-1:0] b_radius;
        logic signed [VEL_W-1:0] b_vel_x;
        logic signed [VEL_W-1:0] b_vel_y;
    } t_item;

    // values carried alongside the root and divider pipelines
    typedef struct packed {
        logic        [RQ_W-1:0]  adx;
        logic        [RQ_W-1:0]  ady;
        logic        [RQ_W-1:0]  rq;
        logic                    sx;
        logic                    sy;
        logic signed [DIF_W-1:0] rvx;
        logic signed [DIF_W-1:0] rvy;
        logic                    nocol;
    } t_side;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > SAT_HI) begin
            res = 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: src/cpci_front.sv
// Front end: differences, early rejects, squares and the overlap compare.
// Three register stages; depends on cpci_pkg.
module cpci_front import cpci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item             i_item,
    output logic              o_valid,
    output logic [SQ_W-1:0]   o_d2,
    output t_side             o_side
);

    // stage A: differences and early rejects
    logic signed [DIF_W-1:0] sA_dx, sA_dy;
    logic        [DIF_W-1:0] sA_adx, sA_ady;
    logic        [RQ_W-1:0]  sA_rq;
    logic                    sA_far, sA_still, sA_zero;

    assign sA_dx  = DIF_W'(i_item.a_pos_x) - DIF_W'(i_item.b_pos_x);
    assign sA_dy  = DIF_W'(i_item.a_pos_y) - DIF_W'(i_item.b_pos_y);
    assign sA_adx = sA_dx[DIF_W-1] ? DIF_W'(-sA_dx) : DIF_W'(sA_dx);
    assign sA_ady = sA_dy[DIF_W-1] ? DIF_W'(-sA_dy) : DIF_W'(sA_dy);
    assign sA_rq  = {(RAD_W+1)'(i_item.a_radius) + (RAD_W+1)'(i_item.b_radius),
                     {FRAC_BITS{1'b0}}};
    // either axis beyond the radius sum already rules out overlap
    assign sA_far   = (sA_adx > DIF_W'(sA_rq)) || (sA_ady > DIF_W'(sA_rq));
    assign sA_still = (i_item.a_vel_x == '0) && (i_item.b_vel_x == '0) &&
                      (i_item.a_vel_y == '0) && (i_item.b_vel_y == '0);
    assign sA_zero  = (sA_adx == '0) && (sA_ady == '0);

    logic  r_a_vld;
    t_side r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
        end
        r_a_side.adx   <= RQ_W'(sA_adx);
        r_a_side.ady   <= RQ_W'(sA_ady);
        r_a_side.rq    <= sA_rq;
        r_a_side.sx    <= sA_dx[DIF_W-1];
        r_a_side.sy    <= sA_dy[DIF_W-1];
        r_a_side.rvx   <= DIF_W'(i_item.a_vel_x) - DIF_W'(i_item.b_vel_x);
        r_a_side.rvy   <= DIF_W'(i_item.a_vel_y) - DIF_W'(i_item.b_vel_y);
        r_a_side.nocol <= sA_far || sA_still || sA_zero;
    end

    // stage B: squares
    logic              r_b_vld;
    t_side             r_b_side;
    logic [SQ_W-1:0]   r_b_x2, r_b_y2, r_b_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_side <= r_a_side;
        r_b_x2   <= r_a_side.adx * r_a_side.adx;
        r_b_y2   <= r_a_side.ady * r_a_side.ady;
        r_b_r2   <= r_a_side.rq * r_a_side.rq;
    end

    // stage C: squared distance against squared radius sum (touching collides)
    logic [D2_W-1:0] sC_d2;
    t_side           sC_side;
    logic            r_c_vld;
    t_side           r_c_side;
    logic [SQ_W-1:0] r_c_d2;

    assign sC_d2 = D2_W'(r_b_x2) + D2_W'(r_b_y2);

    always_comb begin
        sC_side       = r_b_side;
        sC_side.nocol = r_b_side.nocol || (sC_d2 > D2_W'(r_b_r2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_side <= sC_side;
        r_c_d2   <= SQ_W'(sC_d2);
    end

    assign o_valid = r_c_vld;
    assign o_d2    = r_c_d2;
    assign o_side  = r_c_side;

endmodule

FILE: src/cpci_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// RQ_W stages of a narrow compare and subtract; depends on cpci_pkg.
module cpci_sqrt import cpci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [RQ_W-1:0]   o_root,
    output t_side             o_side
);

    logic              r_vld  [RQ_W];
    logic [REM_W-1:0]  r_rem  [RQ_W];
    logic [RQ_W-1:0]   r_root [RQ_W];
    logic [SQ_W-1:0]   r_rad  [RQ_W];
    t_side             r_side [RQ_W];

    for (genvar g = 0; g < RQ_W; g++) begin : g_stage
        logic              s_vld;
        logic [REM_W-1:0]  s_rem, s_sh, s_try;
        logic [RQ_W-1:0]   s_root;
        logic [SQ_W-1:0]   s_rad;
        t_side             s_side;

        if (g == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = i_rad;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[g-1];
            assign s_rem  = r_rem[g-1];
            assign s_root = r_root[g-1];
            assign s_rad  = r_rad[g-1];
            assign s_side = r_side[g-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign s_sh  = {s_rem[REM_W-3:0], s_rad[SQ_W-1 -: 2]};
        assign s_try = {s_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= s_vld;
            end
            if (s_sh >= s_try) begin
                r_rem[g]  <= s_sh - s_try;
                r_root[g] <= {s_root[RQ_W-2:0], 1'b1};
            end else begin
                r_rem[g]  <= s_sh;
                r_root[g] <= {s_root[RQ_W-2:0], 1'b0};
            end
            r_rad[g]  <= {s_rad[SQ_W-3:0], 2'b00};
            r_side[g] <= s_side;
        end
    end

    assign o_valid = r_vld[RQ_W-1];
    assign o_root  = r_root[RQ_W-1];
    assign o_side  = r_side[RQ_W-1];

endmodule

FILE: src/cpci_div.sv
// Pipelined restoring divider, three lanes sharing one divisor.
// NUM_W stages, one quotient bit per lane per stage; depends on cpci_pkg.
module cpci_div import cpci_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]  i_num,
    input  logic [RQ_W-1:0]              i_den,
    input  t_side                        i_side,
    output logic                         o_valid,
    output logic [LANES-1:0][NUM_W-1:0]  o_quo,
    output t_side                        o_side
);

    logic                         r_vld  [NUM_W];
    // dividend shifts out at the top while quotient bits shift in at the bottom
    logic [LANES-1:0][NUM_W-1:0]  r_num  [NUM_W];
    logic [LANES-1:0][RQ_W-1:0]   r_rem  [NUM_W];
    logic [RQ_W-1:0]              r_den  [NUM_W];
    t_side                        r_side [NUM_W];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic                         s_vld;
        logic [LANES-1:0][NUM_W-1:0]  s_num;
        logic [LANES-1:0][RQ_W-1:0]   s_rem;
        logic [RQ_W-1:0]              s_den;
        t_side                        s_side;

        if (g == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_num  = i_num;
            assign s_rem  = '0;
            assign s_den  = i_den;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[g-1];
            assign s_num  = r_num[g-1];
            assign s_rem  = r_rem[g-1];
            assign s_den  = r_den[g-1];
            assign s_side = r_side[g-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [RQ_W:0] s_sh;
            logic          s_q;

            assign s_sh = {s_rem[l], s_num[l][NUM_W-1]};
            assign s_q  = (s_sh >= {1'b0, s_den});

            always_ff @(posedge i_clk) begin
                r_rem[g][l] <= s_q ? RQ_W'(s_sh - {1'b0, s_den}) : RQ_W'(s_sh);
                r_num[g][l] <= {s_num[l][NUM_W-2:0], s_q};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= s_vld;
            end
            r_den[g]  <= s_den;
            r_side[g] <= s_side;
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_num[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

FILE: src/cpci_back.sv
// Back end: normal, dot product, impulse, push, saturation and output word.
// Five register stages, the last one drives the result ports; depends on cpci_pkg.
module cpci_back import cpci_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]  i_quo,
    input  t_side                        i_side,
    output logic                         o_strobe,
    output logic                         o_collided,
    output logic signed [31:0]           o_impulse_x,
    output logic signed [31:0]           o_impulse_y,
    output logic signed [31:0]           o_push_x,
    output logic signed [31:0]           o_push_y
);

    // stage 1: signed normal, then the multiplies
    logic signed [N_W-1:0] s1_nx, s1_ny;
    logic        [N_W-2:0] s1_qx, s1_qy;
    logic        [NUM_W-1:0] s1_ratio;

    assign s1_qx    = i_quo[LANE_X][N_W-2:0];
    assign s1_qy    = i_quo[LANE_Y][N_W-2:0];
    assign s1_ratio = i_quo[LANE_R];
    assign s1_nx    = i_side.sx ? -$signed({1'b0, s1_qx}) : $signed({1'b0, s1_qx});
    assign s1_ny    = i_side.sy ? -$signed({1'b0, s1_qy}) : $signed({1'b0, s1_qy});

    logic                     r1_vld, r1_sx, r1_sy, r1_nocol;
    logic signed [N_W-1:0]    r1_nx, r1_ny;
    logic signed [MP_W-1:0]   r1_mx, r1_my;
    logic [RL_W+RQ_W-1:0]     r1_plx, r1_ply;
    logic [RH_W+RQ_W-1:0]     r1_phx, r1_phy;
    logic [RQ_W-1:0]          r1_adx, r1_ady;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
        end
        r1_nx    <= s1_nx;
        r1_ny    <= s1_ny;
        r1_mx    <= s1_nx * i_side.rvx;
        r1_my    <= s1_ny * i_side.rvy;
        r1_plx   <= s1_ratio[RL_W-1:0] * i_side.adx;
        r1_ply   <= s1_ratio[RL_W-1:0] * i_side.ady;
        r1_phx   <= s1_ratio[NUM_W-1:RL_W] * i_side.adx;
        r1_phy   <= s1_ratio[NUM_W-1:RL_W] * i_side.ady;
        r1_adx   <= i_side.adx;
        r1_ady   <= i_side.ady;
        r1_sx    <= i_side.sx;
        r1_sy    <= i_side.sy;
        r1_nocol <= i_side.nocol;
    end

    // stage 2: dot sum and the ratio products put back together
    logic                     r2_vld, r2_sx, r2_sy, r2_nocol;
    logic signed [N_W-1:0]    r2_nx, r2_ny;
    logic signed [SUM_W-1:0]  r2_sum;
    logic [PP_W-1:0]          r2_prx, r2_pry;
    logic [RQ_W-1:0]          r2_adx, r2_ady;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_sum   <= r1_mx + r1_my;
        r2_prx   <= {r1_phx, {RL_W{1'b0}}} + PP_W'(r1_plx);
        r2_pry   <= {r1_phy, {RL_W{1'b0}}} + PP_W'(r1_ply);
        r2_nx    <= r1_nx;
        r2_ny    <= r1_ny;
        r2_adx   <= r1_adx;
        r2_ady   <= r1_ady;
        r2_sx    <= r1_sx;
        r2_sy    <= r1_sy;
        r2_nocol <= r1_nocol;
    end

    // stage 3: dot scaled down toward zero, push magnitude
    logic signed [SUM_W-1:0] s3_adj;

    assign s3_adj = r2_sum + $signed({{(SUM_W-FRAC_BITS){1'b0}},
                                      {FRAC_BITS{r2_sum[SUM_W-1]}}});

    logic                     r3_vld, r3_sx, r3_sy, r3_nocol;
    logic signed [N_W-1:0]    r3_nx, r3_ny;
    logic signed [DOT_W-1:0]  r3_dot;
    logic [RQ_W-1:0]          r3_pmx, r3_pmy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_dot   <= s3_adj[SUM_W-1:FRAC_BITS];
        r3_pmx   <= r2_prx[NUM_W-1:FRAC_BITS] - r2_adx;
        r3_pmy   <= r2_pry[NUM_W-1:FRAC_BITS] - r2_ady;
        r3_nx    <= r2_nx;
        r3_ny    <= r2_ny;
        r3_sx    <= r2_sx;
        r3_sy    <= r2_sy;
        r3_nocol <= r2_nocol;
    end

    // stage 4: impulse products, signed push
    logic                     r4_vld, r4_nocol;
    logic signed [IP_W-1:0]   r4_ipx, r4_ipy;
    logic signed [PX_W-1:0]   r4_px, r4_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_ipx   <= r3_nx * r3_dot;
        r4_ipy   <= r3_ny * r3_dot;
        r4_px    <= r3_sx ? -$signed({1'b0, r3_pmx}) : $signed({1'b0, r3_pmx});
        r4_py    <= r3_sy ? -$signed({1'b0, r3_pmy}) : $signed({1'b0, r3_pmy});
        r4_nocol <= r3_nocol;
    end

    // stage 5: halve and scale the impulse toward zero, saturate, zero on no collision
    logic signed [IP_W-1:0] s5_adjx, s5_adjy;
    logic signed [IS_W-1:0] s5_ix, s5_iy;

    assign s5_adjx = r4_ipx + $signed({{(IP_W-FRAC_BITS-1){1'b0}},
                                       {(FRAC_BITS+1){r4_ipx[IP_W-1]}}});
    assign s5_adjy = r4_ipy + $signed({{(IP_W-FRAC_BITS-1){1'b0}},
                                       {(FRAC_BITS+1){r4_ipy[IP_W-1]}}});
    assign s5_ix   = s5_adjx[IP_W-1:FRAC_BITS+1];
    assign s5_iy   = s5_adjy[IP_W-1:FRAC_BITS+1];

    logic               r_strobe, r_collided;
    logic signed [31:0] r_ix, r_iy, r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r4_vld;
        end
        r_collided <= !r4_nocol;
        r_ix       <= r4_nocol ? '0 : sat32(64'(s5_ix));
        r_iy       <= r4_nocol ? '0 : sat32(64'(s5_iy));
        r_px       <= r4_nocol ? '0 : sat32(64'(r4_px));
        r_py       <= r4_nocol ? '0 : sat32(64'(r4_py));
    end

    assign o_strobe    = r_strobe;
    assign o_collided  = r_strobe && r_collided;
    assign o_impulse_x = r_ix;
    assign o_impulse_y = r_iy;
    assign o_push_x    = r_px;
    assign o_push_y    = r_py;

endmodule

FILE: src/circle_pair_collision_impulse.sv
// Pipeline: input register, front end, square root (RQ_W stages), divider (NUM_W stages)
// and back end; the square root and the divider each resolve one bit per stage.
// Throughput: one word per cycle; busy is never raised and one result per word.
// Reset: synchronous, active low; clears all valid bits, results in flight are dropped.
module circle_pair_collision_impulse import cpci_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [POS_W-1:0]  i_a_pos_x,
    input  logic signed [POS_W-1:0]  i_a_pos_y,
    input  logic        [RAD_W-1:0]  i_a_radius,
    input  logic signed [VEL_W-1:0]  i_a_vel_x,
    input  logic signed [VEL_W-1:0]  i_a_vel_y,
    input  logic signed [POS_W-1:0]  i_b_pos_x,
    input  logic signed [POS_W-1:0]  i_b_pos_y,
    input  logic        [RAD_W-1:0]  i_b_radius,
    input  logic signed [VEL_W-1:0]  i_b_vel_x,
    input  logic signed [VEL_W-1:0]  i_b_vel_y,
    output logic                     o_strobe,
    output logic                     o_collided,
    output logic signed [31:0]       o_impulse_x,
    output logic signed [31:0]       o_impulse_y,
    output logic signed [31:0]       o_push_x,
    output logic signed [31:0]       o_push_y
);

    // the pipeline never stalls
    assign busy = 1'b0;

    // input word register
    logic  r_in_vld;
    t_item r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        r_in.a_pos_x  <= i_a_pos_x;
        r_in.a_pos_y  <= i_a_pos_y;
        r_in.a_radius <= i_a_radius;
        r_in.a_vel_x  <= i_a_vel_x;
        r_in.a_vel_y  <= i_a_vel_y;
        r_in.b_pos_x  <= i_b_pos_x;
        r_in.b_pos_y  <= i_b_pos_y;
        r_in.b_radius <= i_b_radius;
        r_in.b_vel_x  <= i_b_vel_x;
        r_in.b_vel_y  <= i_b_vel_y;
    end

    // overlap test
    logic            fr_vld;
    logic [SQ_W-1:0] fr_d2;
    t_side           fr_side;

    cpci_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_vld),
        .i_item  (r_in),
        .o_valid (fr_vld),
        .o_d2    (fr_d2),
        .o_side  (fr_side)
    );

    // distance
    logic            sq_vld;
    logic [RQ_W-1:0] sq_root;
    t_side           sq_side;

    cpci_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_vld),
        .i_rad   (fr_d2),
        .i_side  (fr_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // normal components and radius ratio over the distance
    logic [LANES-1:0][NUM_W-1:0] dv_num, dv_quo;
    logic                        dv_vld;
    t_side                       dv_side;

    assign dv_num[LANE_X] = {sq_side.adx, {FRAC_BITS{1'b0}}};
    assign dv_num[LANE_Y] = {sq_side.ady, {FRAC_BITS{1'b0}}};
    assign dv_num[LANE_R] = {sq_side.rq,  {FRAC_BITS{1'b0}}};

    cpci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_num   (dv_num),
        .i_den   (sq_root),
        .i_side  (sq_side),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // impulse and push
    cpci_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dv_vld),
        .i_quo       (dv_quo),
        .i_side      (dv_side),
        .o_strobe    (o_strobe),
        .o_collided  (o_collided),
        .o_impulse_x (o_impulse_x),
        .o_impulse_y (o_impulse_y),
        .o_push_x    (o_push_x),
        .o_push_y    (o_push_y)
    );

`ifndef SYNTHESIS
    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("result strobe missing after pipeline latency");

    // no collision means an all-zero result word
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_collided) |->
        (o_impulse_x == '0 && o_impulse_y == '0 && o_push_x == '0 && o_push_y == '0))
        else $error("nonzero result without collision");

    // both particles at rest never collide
    a_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_a_vel_x == '0 && i_a_vel_y == '0 &&
         i_b_vel_x == '0 && i_b_vel_y == '0) |-> ##LATENCY (o_strobe && !o_collided))
        else $error("collision reported for stationary pair");

    // coincident centres have no normal
    a_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_a_pos_x == i_b_pos_x && i_a_pos_y == i_b_pos_y) |->
        ##LATENCY (o_strobe && !o_collided))
        else $error("collision reported for coincident centres");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for circle_pair_collision_impulse.
// Drives candidate pairs through the start/busy handshake and checks every strobed result
// against an in-bench integer predictor. Depends on cpci_pkg and the block under src.
`timescale 1ns / 1ps

module testbench;
    import cpci_pkg::*;

    localparam int MAX_CYCLES = 400000;
    localparam int DRAIN      = LATENCY + 20;

    typedef struct {
        logic               collided;
        logic signed [31:0] impulse_x;
        logic signed [31:0] impulse_y;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
    } t_response;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_item word = '0;
    logic o_strobe, o_collided;
    logic signed [31:0] o_impulse_x, o_impulse_y, o_push_x, o_push_y;

    t_response pending_responses[$];
    int mismatches = 0;
    int words_sent = 0;
    int hits_seen = 0;
    int cycles = 0;
    int idle_pct = 0;

    always #6 i_clk = ~i_clk;

    circle_pair_collision_impulse dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_pos_x(word.a_pos_x), .i_a_pos_y(word.a_pos_y), .i_a_radius(word.a_radius),
        .i_a_vel_x(word.a_vel_x), .i_a_vel_y(word.a_vel_y),
        .i_b_pos_x(word.b_pos_x), .i_b_pos_y(word.b_pos_y), .i_b_radius(word.b_radius),
        .i_b_vel_x(word.b_vel_x), .i_b_vel_y(word.b_vel_y),
        .o_strobe(o_strobe), .o_collided(o_collided),
        .o_impulse_x(o_impulse_x), .o_impulse_y(o_impulse_y),
        .o_push_x(o_push_x), .o_push_y(o_push_y)
    );

    // clamp to signed 32
    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // divide by 2^s truncating toward zero
    function automatic logic signed [127:0] shift_tz(input logic signed [127:0] v, input int s);
        logic signed [127:0] mag;
        mag = (v < 0) ? -v : v;
        mag = mag >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    // collision response of one pair
    function automatic t_response pair_response(input t_item p);
        t_response r;
        logic signed [127:0] dx, dy, adx, ady, d2, rq, rq2, root, t;
        logic signed [127:0] nx, ny, rvx, rvy, dot, ratio, px, py;
        r = '{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
        if (p.a_vel_x == 0 && p.b_vel_x == 0 && p.a_vel_y == 0 && p.b_vel_y == 0)
            return r;
        dx = 128'(p.a_pos_x) - 128'(p.b_pos_x);
        dy = 128'(p.a_pos_y) - 128'(p.b_pos_y);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        d2 = adx * adx + ady * ady;
        rq = (128'(p.a_radius) + 128'(p.b_radius)) <<< FRAC_BITS;
        rq2 = rq * rq;
        if (d2 == 0 || d2 > rq2) return r;
        root = 0;
        for (int b = 34; b >= 0; b--) begin
            t = root | (128'sd1 <<< b);
            if (t * t <= d2) root = t;
        end
        nx = (adx <<< FRAC_BITS) / root;
        ny = (ady <<< FRAC_BITS) / root;
        if (dx < 0) nx = -nx;
        if (dy < 0) ny = -ny;
        rvx = 128'(p.a_vel_x) - 128'(p.b_vel_x);
        rvy = 128'(p.a_vel_y) - 128'(p.b_vel_y);
        dot = shift_tz(nx * rvx + ny * rvy, FRAC_BITS);
        ratio = (rq <<< FRAC_BITS) / root;
        px = ((ratio * adx) >>> FRAC_BITS) - adx;
        py = ((ratio * ady) >>> FRAC_BITS) - ady;
        if (dx < 0) px = -px;
        if (dy < 0) py = -py;
        r.collided = 1'b1;
        r.impulse_x = clamp32(shift_tz(nx * dot, FRAC_BITS + 1));
        r.impulse_y = clamp32(shift_tz(ny * dot, FRAC_BITS + 1));
        r.push_x = clamp32(px);
        r.push_y = clamp32(py);
        return r;
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_response exp_r;
        if (i_rst_n && o_strobe) begin
            if (pending_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at cycle %0d", cycles);
            end else begin
                exp_r = pending_responses.pop_front();
                if (exp_r.collided) hits_seen++;
                if (o_collided !== exp_r.collided || o_impulse_x !== exp_r.impulse_x ||
                    o_impulse_y !== exp_r.impulse_y || o_push_x !== exp_r.push_x ||
                    o_push_y !== exp_r.push_y) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: exp c=%0d ix=%0d iy=%0d px=%0d py=%0d",
                                 exp_r.collided, exp_r.impulse_x, exp_r.impulse_y,
                                 exp_r.push_x, exp_r.push_y);
                        $display("          got c=%0d ix=%0d iy=%0d px=%0d py=%0d",
                                 o_collided, o_impulse_x, o_impulse_y,
                                 o_push_x, o_push_y);
                    end
                end
            end
        end
    end

    // send one word, with a random idle gap before it; start stays high afterwards
    task automatic send_word(input t_item p);
        if (idle_pct > 0) begin
            while ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        word <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_responses.insert(pending_responses.size(), pair_response(p));
        words_sent++;
    endtask

    // stop sending and wait for every expected result
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_fixed();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 10;
            2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            default: return 32'($signed($urandom_range(400)) - 200) <<< FRAC_BITS;
        endcase
    endfunction

    // pair likely to overlap: B placed near A, each axis offset within the radius sum plus one
    function automatic t_item near_pair();
        t_item p;
        int span;
        p.a_radius = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 20));
        p.b_radius = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 20));
        span = (int'(p.a_radius) + int'(p.b_radius) + 1) << FRAC_BITS;
        p.a_pos_x = $urandom();
        p.a_pos_y = $urandom();
        p.b_pos_x = p.a_pos_x + 32'($signed($urandom_range(2 * span)) - span);
        p.b_pos_y = p.a_pos_y + 32'($signed($urandom_range(2 * span)) - span);
        p.a_vel_x = rand_fixed();
        p.a_vel_y = rand_fixed();
        p.b_vel_x = rand_fixed();
        p.b_vel_y = rand_fixed();
        if ($urandom_range(19) == 0) {p.a_vel_x, p.a_vel_y, p.b_vel_x, p.b_vel_y} = '0;
        return p;
    endfunction

    function automatic t_item any_pair();
        t_item p;
        p = {$urandom(), $urandom(), 8'($urandom()), $urandom(), $urandom(),
             $urandom(), $urandom(), 8'($urandom()), $urandom(), $urandom()};
        return p;
    endfunction

    // directed corner cases
    task automatic test_directed();
        t_item p;
        p = '0; p.a_radius = 8'd5; p.b_radius = 8'd5;
        p.a_pos_x = 32'sh0003_0000;
        send_word(p);                                   // both stationary, overlapping
        p.a_vel_x = 32'sh0001_0000;
        send_word(p);                                   // head-on overlap
        p.a_pos_x = 32'sh000A_0000; send_word(p);       // exactly touching
        p.a_pos_x = 32'sh000A_0001; send_word(p);       // just apart
        p.a_pos_x = 0; send_word(p);                    // coincident centres
        p.a_radius = 0; p.b_radius = 0;
        p.a_pos_x = 32'sh0000_0001; send_word(p);       // zero radius sum
        p.a_radius = 8'hFF; p.b_radius = 8'hFF;
        p.a_pos_x = 32'sh0000_0001; p.a_pos_y = -32'sh0000_0001;
        p.a_vel_x = 32'sh7FFF_FFFF; p.a_vel_y = 32'sh8000_0000;
        p.b_vel_x = 32'sh8000_0000; p.b_vel_y = 32'sh7FFF_FFFF;
        send_word(p);                                   // saturating impulse, huge push
        p.a_pos_x = 32'sh7FFF_FFFF; p.b_pos_x = 32'sh7FFF_0000;
        p.a_pos_y = 32'sh8000_0000; p.b_pos_y = 32'sh8000_FFFF;
        send_word(p);                                   // position extremes
        p.a_pos_x = 32'sh8000_0000; p.b_pos_x = 32'sh7FFF_FFFF; send_word(p); // far apart
        p = '0; p.b_radius = 8'd3; p.b_vel_y = -32'sh0002_0000;
        p.b_pos_x = 32'sh0001_0000; p.b_pos_y = -32'sh0001_0000;
        send_word(p);                                   // negative offsets
        for (int k = 0; k < 10; k++) send_word(any_pair());
        wait_drained();                                 // sender holds off until drained
    endtask

    // random pairs under one idle setting
    task automatic test_random(input int pct, input int count);
        idle_pct = pct;
        for (int k = 0; k < count; k++)
            send_word(($urandom_range(9) < 8) ? near_pair() : any_pair());
        idle_pct = 0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(0, 340);
        test_random(45, 340);
        test_random(0, 330);
        test_random(12, 330);
        wait_drained();
        repeat (DRAIN) @(posedge i_clk);
        $display("Covered %0d pairs, %0d of them colliding, under several idle patterns.",
                 words_sent, hits_seen);
        if (mismatches == 0 && pending_responses.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Mismatches: %0d, missing: %0d", mismatches, pending_responses.size());
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
